// ===== sv/sms_pkg.sv =====
// ----------------------------------------------------------------------------
// sms_pkg: shared types and constants for the sorted matrix search block
// Request and result structs, RAM port bundle, sizes and codes.
// ----------------------------------------------------------------------------
package sms_pkg;

	// matrix geometry
	localparam int MAX_ROWS = 32;
	localparam int MAX_COLS = 32;
	localparam int DEPTH    = MAX_ROWS * MAX_COLS;

	localparam int ROW_W  = $clog2(MAX_ROWS);     // row number
	localparam int COL_W  = $clog2(MAX_COLS);     // column number
	localparam int RCNT_W = $clog2(MAX_ROWS + 1); // row count 0..MAX_ROWS
	localparam int CCNT_W = $clog2(MAX_COLS + 1); // column count 0..MAX_COLS
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int DATA_W = 32;

	// configuration registers
	localparam int CFG_W = 6;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 1'd1;
	localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

	// request codes
	localparam logic FUNC_WRITE  = 1'b0;
	localparam logic FUNC_SEARCH = 1'b1;

	typedef struct packed {
		logic               func;
		logic [4:0]         row_sel;
		logic [4:0]         col_sel;
		logic signed [31:0] entry_value;
		logic signed [31:0] search_key;
	} req_t;

	typedef struct packed {
		logic       found;
		logic [5:0] row_index;
		logic [4:0] col_index;
	} rsp_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [DATA_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	// linear address of one matrix entry
	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col);
		return ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_COLS) + ADDR_W'(col));
	endfunction

endpackage

// ===== sv/sms_ram.sv =====
// ----------------------------------------------------------------------------
// sms_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sms_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/sms_seq.sv =====
// ----------------------------------------------------------------------------
// sms_seq: request sequencer
// Performs entry writes and, for a search, the last-column lower-bound
// search followed by the in-row exact search, one RAM probe per cycle.
// ----------------------------------------------------------------------------
module sms_seq
	import sms_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  req_t              req,
	input  logic [RCNT_W-1:0] rows,
	input  logic [COL_W-1:0]  last_col,
	output ram_req_t          ram,
	input  logic [DATA_W-1:0] rd_data,
	output logic              res_valid,
	input  logic              res_stall,
	output rsp_t              res
);

	typedef enum logic [1:0] {S_IDLE, S_ROW, S_COL, S_DONE} state_t;

	state_t              state_q;
	logic signed [31:0]  key_q;
	logic [RCNT_W-1:0]   rows_q;
	logic [COL_W-1:0]    last_q;
	logic [RCNT_W-1:0]   lo_q, hi_q;
	logic [ROW_W-1:0]    mid_q;
	logic [ROW_W-1:0]    row_q;
	logic [COL_W-1:0]    clo_q, chi_q, cmid_q;
	rsp_t                res_q;

	logic                accept;
	logic                rd_lt, rd_eq;
	logic [RCNT_W-1:0]   nlo, nhi;
	logic                row_more, row_hit;
	logic [ROW_W-1:0]    nmid, mid0;
	logic [COL_W-1:0]    cmid0;
	logic [COL_W-1:0]    nclo, nchi, ncmid;
	logic                col_end;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	assign rd_lt = $signed(rd_data) < key_q;
	assign rd_eq = $signed(rd_data) == key_q;

	// row search step: last[mid] < key moves lo up, else hi down
	always_comb begin
		nlo = rd_lt ? RCNT_W'(RCNT_W'(mid_q) + 1'b1) : lo_q;
		nhi = rd_lt ? hi_q : RCNT_W'(mid_q);
		row_more = nlo < nhi;
		nmid = ROW_W'(((RCNT_W+1)'(nlo) + (RCNT_W+1)'(nhi)) >> 1);
		row_hit = nlo < rows_q;
		mid0 = ROW_W'(rows >> 1);
		cmid0 = last_q >> 1;
	end

	// column search step; range empties when mid meets the moving bound
	always_comb begin
		nclo = clo_q;
		nchi = chi_q;
		col_end = 1'b0;
		if (rd_eq) begin
			col_end = 1'b1;
		end else if (rd_lt) begin
			col_end = (cmid_q == chi_q);
			nclo = COL_W'(cmid_q + 1'b1);
		end else begin
			col_end = (cmid_q == clo_q);
			nchi = COL_W'(cmid_q - 1'b1);
		end
		ncmid = COL_W'(((COL_W+1)'(nclo) + (COL_W+1)'(nchi)) >> 1);
	end

	// RAM requests
	always_comb begin
		ram = '0;
		case (state_q)
			S_IDLE: begin
				if (accept && req.func == FUNC_WRITE) begin
					ram.we = (32'(req.row_sel) < 32'(MAX_ROWS))
						&& (32'(req.col_sel) < 32'(MAX_COLS));
					ram.waddr = cell_addr(ROW_W'(req.row_sel), COL_W'(req.col_sel));
					ram.wdata = req.entry_value;
				end else if (accept) begin
					ram.re = 1'b1;
					ram.raddr = cell_addr(mid0, last_col);
				end
			end
			S_ROW: begin
				if (row_more) begin
					ram.re = 1'b1;
					ram.raddr = cell_addr(nmid, last_q);
				end else if (row_hit) begin
					ram.re = 1'b1;
					ram.raddr = cell_addr(ROW_W'(nlo), cmid0);
				end
			end
			S_COL: begin
				if (!col_end) begin
					ram.re = 1'b1;
					ram.raddr = cell_addr(row_q, ncmid);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						key_q  <= req.search_key;
						rows_q <= rows;
						last_q <= last_col;
						lo_q   <= '0;
						hi_q   <= rows;
						mid_q  <= mid0;
						res_q  <= '0;
						state_q <= (req.func == FUNC_WRITE) ? S_DONE : S_ROW;
					end
				end
				S_ROW: begin
					lo_q <= nlo;
					hi_q <= nhi;
					mid_q <= nmid;
					if (!row_more) begin
						res_q.row_index <= 6'(nlo);
						row_q  <= ROW_W'(nlo);
						clo_q  <= '0;
						chi_q  <= last_q;
						cmid_q <= cmid0;
						state_q <= row_hit ? S_COL : S_DONE;
					end
				end
				S_COL: begin
					clo_q  <= nclo;
					chi_q  <= nchi;
					cmid_q <= ncmid;
					if (rd_eq) begin
						res_q.found <= 1'b1;
						res_q.col_index <= 5'(cmid_q);
					end
					if (col_end) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!res_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sv/sorted_matrix_search.sv =====
// ----------------------------------------------------------------------------
// sorted_matrix_search: binary search in a row-sorted matrix
// Stores signed entries in a RAM and looks a key up by a lower-bound search
// on the last column followed by an exact search in the chosen row.
// ----------------------------------------------------------------------------
//
//  channel   signals                              dir  payload
//  --------  -----------------------------------  ---  ----------------------
//  request   in_valid / in_stall / in_data        in   req_t (func, sel, key)
//  result    out_valid / out_stall / out_data     out  rsp_t (found, row, col)
//  config    cfg_we / cfg_index / cfg_data        in   rows_in_use, cols_in_use
//
// A search makes up to 6 RAM probes on the last column and 6 within the row
// with the default 32x32 matrix, one at a time through the single read port
// of the RAM, whose read data is registered.
// A request is taken only when the sequencer is idle; a finished result
// waits in the output register while the next request is taken.
// Reset sets both counts to 32; the matrix RAM is not cleared and has no
// clearing pass, entries hold whatever was last written.
// ----------------------------------------------------------------------------
module sorted_matrix_search
	import sms_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  req_t                 in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output rsp_t                 out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [CFG_W-1:0]  rows_cfg_q, cols_cfg_q;
	logic [RCNT_W-1:0] rows_eff;
	logic [CCNT_W-1:0] cols_eff;
	logic [COL_W-1:0]  last_col;

	ram_req_t          ram;
	logic [DATA_W-1:0] rd_data;

	logic              res_valid, res_stall;
	rsp_t              res;

	logic              out_valid_q;
	rsp_t              out_data_q;

	// configuration registers; the user must write them only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q <= CFG_RESET;
			cols_cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROWS_IN_USE: rows_cfg_q <= cfg_data;
				REG_COLS_IN_USE: cols_cfg_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// counts: zero acts as one, too large acts as the matrix size
	always_comb begin
		if (rows_cfg_q == '0) begin
			rows_eff = RCNT_W'(1);
		end else if (32'(rows_cfg_q) > 32'(MAX_ROWS)) begin
			rows_eff = RCNT_W'(MAX_ROWS);
		end else begin
			rows_eff = RCNT_W'(rows_cfg_q);
		end
		if (cols_cfg_q == '0) begin
			cols_eff = CCNT_W'(1);
		end else if (32'(cols_cfg_q) > 32'(MAX_COLS)) begin
			cols_eff = CCNT_W'(MAX_COLS);
		end else begin
			cols_eff = CCNT_W'(cols_cfg_q);
		end
		last_col = COL_W'(cols_eff - 1'b1);
	end

	sms_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram.we),
		.waddr (ram.waddr),
		.wdata (ram.wdata),
		.re    (ram.re),
		.raddr (ram.raddr),
		.rdata (rd_data)
	);

	sms_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (in_valid),
		.req_stall (in_stall),
		.req       (in_data),
		.rows      (rows_eff),
		.last_col  (last_col),
		.ram       (ram),
		.rd_data   (rd_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	// output register: loads when empty or being drained this cycle
	assign res_stall = out_valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!res_stall) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && !res_stall) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== bench/sorted_matrix_search_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_matrix_search_tb: self-checking bench for the sorted matrix search
// Sends write and search requests and predicts every result in the bench.
// It moves through row and column counts, the clamped extremes among them,
// with random idling on both sides and one long result stall.
// ----------------------------------------------------------------------------
module sorted_matrix_search_tb;
	import sms_pkg::*;

	localparam int CYCLE_LIMIT = 500_000;
	localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	req_t                 in_data   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	rsp_t                 out_data;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;

	// bench copy of the block's state
	logic signed [31:0] cells [MAX_ROWS][MAX_COLS];
	bit                 written [MAX_ROWS][MAX_COLS];
	logic [CFG_W-1:0]   rows_cfg = CFG_RESET;
	logic [CFG_W-1:0]   cols_cfg = CFG_RESET;

	rsp_t predicted_answers [$];
	rsp_t want;
	int   errors        = 0;
	int   requests_sent = 0;
	int   cycle_count   = 0;
	bit   no_idle       = 1'b0; // both sides run without gaps
	int   result_wait   = 0;    // receiver stall left for the current result
	int   hold_left     = 0;    // long receiver hold-off
	int   hold_req      = 0;    // set by a test to start a hold-off

	sorted_matrix_search dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("sorted_matrix_search test failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// a count of 0 acts as 1, anything above the matrix size as the size
	function automatic int eff_count(input logic [CFG_W-1:0] v, input int limit);
		if (v == 0)
			return 1;
		if (v > limit)
			return limit;
		return int'(v);
	endfunction

	// Runs both binary searches on the bench copy. Returns 0 if any probe
	// touches an entry that was never written, so such keys are never sent.
	function automatic bit search_cells(input logic signed [31:0] key, output rsp_t res);
		int  rows, last, lo, hi, mid;
		bit  safe;
		safe = 1'b1;
		res  = '0;
		rows = eff_count(rows_cfg, MAX_ROWS);
		last = eff_count(cols_cfg, MAX_COLS) - 1;
		// lower bound on the last column: first row whose last entry >= key
		lo = 0;
		hi = rows;
		while (lo < hi) begin
			mid = (lo + hi) / 2;
			safe &= written[mid][last];
			if (cells[mid][last] < key)
				lo = mid + 1;
			else
				hi = mid;
		end
		res.row_index = lo[5:0];
		// exact search within the chosen row; beyond the table skips it
		if (lo < rows) begin
			int c_lo, c_hi, row;
			row  = lo;
			c_lo = 0;
			c_hi = last;
			while (c_lo <= c_hi) begin
				mid = (c_lo + c_hi) / 2;
				safe &= written[row][mid];
				if (cells[row][mid] == key) begin
					res.found     = 1'b1;
					res.col_index = mid[4:0];
					break;
				end else if (cells[row][mid] < key) begin
					c_lo = mid + 1;
				end else begin
					c_hi = mid - 1;
				end
			end
		end
		return safe;
	endfunction

	// expected result of one accepted request; a write updates the copy
	// and answers all zeros (row_sel/col_sel are 5 bits, always in range)
	function automatic rsp_t predict_answer(input req_t req);
		rsp_t res;
		res = '0;
		if (req.func == FUNC_WRITE) begin
			cells[req.row_sel][req.col_sel]   = req.entry_value;
			written[req.row_sel][req.col_sel] = 1'b1;
		end else begin
			void'(search_cells(req.search_key, res));
		end
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Request builders; fields a request does not use carry noise
	// ------------------------------------------------------------------

	function automatic req_t write_req(input int r, input int c,
			input logic signed [31:0] v);
		req_t req;
		req.func        = FUNC_WRITE;
		req.row_sel     = 5'(r);
		req.col_sel     = 5'(c);
		req.entry_value = v;
		req.search_key  = $urandom;
		return req;
	endfunction

	function automatic req_t search_req(input logic signed [31:0] key);
		req_t req;
		req.func        = FUNC_SEARCH;
		req.row_sel     = 5'($urandom);
		req.col_sel     = 5'($urandom);
		req.entry_value = $urandom;
		req.search_key  = key;
		return req;
	endfunction

	// Random request for the current table. Search keys lean toward stored
	// values and their neighbors; a key whose probes would hit an unwritten
	// entry is redrawn, and after enough misses a write goes out instead.
	function automatic req_t make_item(input int write_pct);
		logic signed [31:0] key;
		rsp_t               scratch;
		int                 tries, pr, pc, sel;
		if ($urandom_range(0, 99) < write_pct)
			return write_req($urandom_range(0, 31), $urandom_range(0, 31), $urandom);
		for (tries = 0; tries < 32; tries++) begin
			pr  = $urandom_range(0, eff_count(rows_cfg, MAX_ROWS) - 1);
			pc  = $urandom_range(0, eff_count(cols_cfg, MAX_COLS) - 1);
			sel = $urandom_range(0, 9);
			if (sel < 6 && !written[pr][pc])
				sel = 9;
			case (sel)
				0, 1, 2, 3: key = cells[pr][pc];
				4:          key = cells[pr][pc] + 1;
				5:          key = cells[pr][pc] - 1;
				6:          key = KEY_MIN;
				7:          key = KEY_MAX;
				default:    key = $urandom;
			endcase
			if (search_cells(key, scratch))
				return search_req(key);
		end
		return write_req($urandom_range(0, 31), $urandom_range(0, 31), $urandom);
	endfunction

	// mostly small counts, sometimes 0, the full size or above it
	function automatic logic [CFG_W-1:0] draw_count();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return 6'd32;
			2:       return 6'($urandom_range(33, 63));
			3:       return 6'd1;
			default: return 6'($urandom_range(2, 8));
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------

	// Offers one request and returns at the edge that takes it. Valid stays
	// high when the next request follows with no gap.
	task automatic send_request(input req_t req);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted_answers.push_back(predict_answer(req));
		requests_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (predicted_answers.size() != 0)
			@(posedge clk);
	endtask

	// Every request yields a result, so once the queue is empty the
	// sequencer is idle and the counts may change.
	task automatic set_counts(input logic [CFG_W-1:0] rows_val,
			input logic [CFG_W-1:0] cols_val);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_index <= REG_ROWS_IN_USE;
		cfg_data  <= rows_val;
		@(posedge clk);
		rows_cfg = rows_val;
		cfg_index <= REG_COLS_IN_USE;
		cfg_data  <= cols_val;
		@(posedge clk);
		cols_cfg = cols_val;
		cfg_we <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------

	// After each result the receiver draws how long to stall the next one;
	// the count runs only while a result is shown. A test may also start a
	// long hold-off that runs on its own.
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			result_wait = no_idle ? 0 : $urandom_range(0, 12);
		else if (out_valid && result_wait > 0)
			result_wait--;
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end else if (hold_left > 0) begin
			hold_left--;
		end
		out_stall <= (hold_left > 0) || (result_wait > 0);
	end

	function automatic void flag_mismatch(input string what, input logic [31:0] want_v,
			input logic [31:0] got_v);
		errors++;
		// keep the log readable when the block is badly off
		if (errors <= 100)
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want_v, got_v);
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (predicted_answers.size() == 0) begin
				errors++;
				$display("%0t: result with none pending: expected none, got %h",
					$time, out_data);
			end else begin
				want = predicted_answers.pop_front();
				if (out_data.found !== want.found)
					flag_mismatch("found", 32'(want.found), 32'(out_data.found));
				if (out_data.row_index !== want.row_index)
					flag_mismatch("row_index", 32'(want.row_index),
						32'(out_data.row_index));
				if (out_data.col_index !== want.col_index)
					flag_mismatch("col_index", 32'(want.col_index),
						32'(out_data.col_index));
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Both counts come out of reset at 32. A key above every last-column
	// entry walks rows 16, 24, 28, 30, 31 and lands beyond the table (32).
	task automatic test_reset_counts();
		send_request(write_req(16, 31, 1000));
		send_request(write_req(24, 31, 1001));
		send_request(write_req(28, 31, 1002));
		send_request(write_req(30, 31, 1003));
		send_request(write_req(31, 31, 1004));
		send_request(search_req(KEY_MAX));
	endtask

	// zero counts act as a 1x1 table; counts above 32 act as 32
	task automatic test_count_clamping();
		set_counts('0, '0);
		send_request(write_req(0, 0, KEY_MIN));
		send_request(search_req(KEY_MIN));
		send_request(search_req(KEY_MAX));
		set_counts(6'd63, 6'd33);
		send_request(search_req(KEY_MAX));
	endtask

	// 2x3 table holding both value extremes: hits, a key missing from its
	// row, a key equal to a last entry, then a row made unsorted on purpose
	task automatic test_small_table();
		set_counts(6'd2, 6'd3);
		send_request(write_req(0, 0, KEY_MIN));
		send_request(write_req(0, 1, -5));
		send_request(write_req(0, 2, 0));
		send_request(write_req(1, 0, 0));
		send_request(write_req(1, 1, 7));
		send_request(write_req(1, 2, KEY_MAX));
		send_request(search_req(-5));
		send_request(search_req(3));
		send_request(search_req(0));
		send_request(search_req(KEY_MIN));
		send_request(search_req(KEY_MAX));
		send_request(write_req(1, 0, 100));
		send_request(search_req(100));
		send_request(search_req(7));
	endtask

	// One table: new counts, fill, then searches with a little write noise.
	// Small tables are filled whole. Large ones get only the last column and
	// one or two full rows, and keys are picked so the searches stay on them.
	task automatic run_table_phase();
		logic signed [31:0] fill [MAX_ROWS][MAX_COLS];
		longint             acc;
		int                 rows, cols, step_cap, n_search, r, c, k, row_a, row_b;
		bit                 sorted, sparse;
		set_counts(draw_count(), draw_count());
		no_idle  = ($urandom_range(0, 4) == 0);
		rows     = eff_count(rows_cfg, MAX_ROWS);
		cols     = eff_count(cols_cfg, MAX_COLS);
		sorted   = ($urandom_range(0, 6) != 0);
		sparse   = (rows * cols > 64);
		case ($urandom_range(0, 3))
			0:       step_cap = 0;
			1:       step_cap = 3;
			2:       step_cap = 1000;
			default: step_cap = 1 << 24;
		endcase
		case ($urandom_range(0, 2))
			0:       acc = longint'(KEY_MIN);
			1:       acc = longint'(int'($urandom));
			default: acc = -longint'($urandom_range(0, 50));
		endcase
		// row-major ascending keeps rows and the last column sorted
		for (r = 0; r < rows; r++)
			for (c = 0; c < cols; c++) begin
				fill[r][c] = sorted ? acc[31:0] : $urandom;
				acc += $urandom_range(0, step_cap);
				if (acc > KEY_MAX)
					acc = longint'(KEY_MAX);
			end
		row_a = $urandom_range(0, rows - 1);
		row_b = $urandom_range(0, rows - 1);
		for (r = 0; r < rows; r++)
			for (c = 0; c < cols; c++)
				if (!sparse || c == cols - 1 || r == row_a || r == row_b)
					send_request(write_req(r, c, fill[r][c]));
		n_search = sparse ? 40 : $urandom_range(4, 40);
		for (k = 0; k < n_search; k++)
			send_request(make_item(8));
	endtask

	task automatic test_random_tables();
		int stop_at;
		stop_at = requests_sent + 1000;
		while (requests_sent < stop_at)
			run_table_phase();
		no_idle = 1'b0;
	endtask

	// receiver holds off while requests keep coming with no
	// gaps, so the output register fills and the block stalls its input
	task automatic test_output_backpressure();
		int k;
		no_idle  = 1'b1;
		hold_req = 300;
		for (k = 0; k < 30; k++)
			send_request(make_item(30));
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_counts();
		test_count_clamping();
		test_small_table();
		test_random_tables();
		test_output_backpressure();

		drain_results();
		// room for any stray result to show up
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("sorted_matrix_search test passed");
		else
			$display("sorted_matrix_search test failed");
		$finish;
	end

endmodule
